/* hw/rtl/page_frame_free_list_allocator_top_defines.svh */
// Assertion macros for the page frame allocator checker.
// Depends on a clk and an active-low rst_n in the scope that uses them.
`ifndef PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH
`define PAGE_FRAME_FREE_LIST_ALLOCATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PFA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PFA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/pfa_pkg.sv */
// Shared types and constants for the page frame free list allocator.
// No dependencies.
package pfa_pkg;

    localparam int PAGE_TOTAL_DEF  = 128;
    localparam int PAGE_SHIFT_DEF  = 21;
    localparam int MAX_REQUEST_DEF = 64;

    localparam int PAGE_W   = 7;
    localparam int COUNT_W  = 7;
    localparam int ADDR_W   = 28;
    localparam int STATUS_W = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_SHORT   = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ZERO    = 2'd2;

    typedef struct packed {
        logic wr_en;
        logic rd_en;
    } pfa_mem_cmd_t;

endpackage

/* hw/rtl/page_frame_free_list_allocator_top.sv */
// Page frame free list allocator, top level. An allocation of N pages first makes N
// dependent next-link reads to check the list, then pops one result per cycle while
// the output is not stalled. A free gives no result; one that ends a run also splices it.
// Throughput is set by the single read port of the next-link store.
// After reset a clearing pass writes every page's link to build the list; input stalls meanwhile.
// Depends on pfa_pkg, pfa_link_mem and pfa_engine.
module page_frame_free_list_allocator_top #(
    parameter int PAGE_TOTAL  = pfa_pkg::PAGE_TOTAL_DEF,
    parameter int PAGE_SHIFT  = pfa_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_REQUEST = pfa_pkg::MAX_REQUEST_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [pfa_pkg::COUNT_W-1:0]    page_count,
    input  logic [pfa_pkg::PAGE_W-1:0]     freed_page,
    input  logic                           run_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pfa_pkg::PAGE_W-1:0]     granted_page,
    output logic [pfa_pkg::ADDR_W-1:0]     page_address,
    output logic [pfa_pkg::STATUS_W-1:0]   status,
    output logic                           last_of_run
);

    localparam int IDX_W  = $clog2(PAGE_TOTAL);
    localparam int LINK_W = $clog2(PAGE_TOTAL + 1);

    pfa_pkg::pfa_mem_cmd_t mem_cmd;
    logic [IDX_W-1:0]      mem_waddr;
    logic [LINK_W-1:0]     mem_wdata;
    logic [IDX_W-1:0]      mem_raddr;
    logic [LINK_W-1:0]     mem_rdata;

    pfa_link_mem #(
        .DEPTH (PAGE_TOTAL),
        .AW    (IDX_W),
        .DW    (LINK_W)
    ) u_link_mem (
        .clk   (clk),
        .cmd   (mem_cmd),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfa_engine #(
        .PAGE_TOTAL  (PAGE_TOTAL),
        .PAGE_SHIFT  (PAGE_SHIFT),
        .MAX_REQUEST (MAX_REQUEST),
        .IDX_W       (IDX_W),
        .LINK_W      (LINK_W)
    ) u_engine (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .page_count   (page_count),
        .freed_page   (freed_page),
        .run_end      (run_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_page (granted_page),
        .page_address (page_address),
        .status       (status),
        .last_of_run  (last_of_run),
        .mem_cmd      (mem_cmd),
        .mem_waddr    (mem_waddr),
        .mem_wdata    (mem_wdata),
        .mem_raddr    (mem_raddr),
        .mem_rdata    (mem_rdata)
    );

endmodule

/* hw/rtl/pfa_link_mem.sv */
// Next-link store: one write port and one read port with registered read data.
// Depends on pfa_pkg for the command struct.
module pfa_link_mem #(
    parameter int DEPTH = pfa_pkg::PAGE_TOTAL_DEF,
    parameter int AW    = $clog2(pfa_pkg::PAGE_TOTAL_DEF),
    parameter int DW    = $clog2(pfa_pkg::PAGE_TOTAL_DEF + 1)
) (
    input  logic                  clk,
    input  pfa_pkg::pfa_mem_cmd_t cmd,
    input  logic [AW-1:0]         waddr,
    input  logic [DW-1:0]         wdata,
    input  logic [AW-1:0]         raddr,
    output logic [DW-1:0]         rdata
);

    logic [DW-1:0] mem [DEPTH];
    logic [DW-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hw/rtl/pfa_engine.sv */
// Allocation and free sequencer with the result register.
// Depends on pfa_pkg; drives the next-link store in pfa_link_mem.
module pfa_engine #(
    parameter int PAGE_TOTAL  = pfa_pkg::PAGE_TOTAL_DEF,
    parameter int PAGE_SHIFT  = pfa_pkg::PAGE_SHIFT_DEF,
    parameter int MAX_REQUEST = pfa_pkg::MAX_REQUEST_DEF,
    parameter int IDX_W       = $clog2(pfa_pkg::PAGE_TOTAL_DEF),
    parameter int LINK_W      = $clog2(pfa_pkg::PAGE_TOTAL_DEF + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_stall,
    input  logic                           opcode,
    input  logic [pfa_pkg::COUNT_W-1:0]    page_count,
    input  logic [pfa_pkg::PAGE_W-1:0]     freed_page,
    input  logic                           run_end,
    output logic                           out_valid,
    input  logic                           out_stall,
    output logic [pfa_pkg::PAGE_W-1:0]     granted_page,
    output logic [pfa_pkg::ADDR_W-1:0]     page_address,
    output logic [pfa_pkg::STATUS_W-1:0]   status,
    output logic                           last_of_run,
    output pfa_pkg::pfa_mem_cmd_t          mem_cmd,
    output logic [IDX_W-1:0]               mem_waddr,
    output logic [LINK_W-1:0]              mem_wdata,
    output logic [IDX_W-1:0]               mem_raddr,
    input  logic [LINK_W-1:0]              mem_rdata
);

    localparam int COUNT_W  = pfa_pkg::COUNT_W;
    localparam int PAGE_W   = pfa_pkg::PAGE_W;
    localparam int ADDR_W   = pfa_pkg::ADDR_W;
    localparam int STATUS_W = pfa_pkg::STATUS_W;
    localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(PAGE_TOTAL);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(PAGE_TOTAL - 1);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_POP,
        ST_REPORT,
        ST_SPLICE
    } state_t;

    state_t                state_reg, state_next;
    logic [LINK_W-1:0]     head_reg, head_next;
    logic [LINK_W-1:0]     cur_reg, cur_next;
    logic [IDX_W-1:0]      run_first_reg, run_first_next;
    logic [IDX_W-1:0]      run_latest_reg, run_latest_next;
    logic                  run_open_reg, run_open_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    step_reg, step_next;
    logic [IDX_W-1:0]      clr_idx_reg, clr_idx_next;
    logic [STATUS_W-1:0]   report_reg, report_next;
    logic                  out_valid_reg, out_valid_next;
    logic [PAGE_W-1:0]     out_page_reg, out_page_next;
    logic [ADDR_W-1:0]     out_addr_reg, out_addr_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;

    logic                  out_free;
    logic                  rdata_null;
    logic                  head_null;
    logic                  in_range;
    logic [IDX_W-1:0]      in_page;
    logic [IDX_W-1:0]      cur_idx;

    assign out_free   = !out_valid_reg || !out_stall;
    assign rdata_null = mem_rdata >= NULL_LINK;
    assign head_null  = head_reg >= NULL_LINK;
    assign in_range   = 32'(freed_page) < 32'(PAGE_TOTAL);
    assign in_page    = IDX_W'(freed_page);
    assign cur_idx    = IDX_W'(cur_reg);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        cur_next        = cur_reg;
        run_first_next  = run_first_reg;
        run_latest_next = run_latest_reg;
        run_open_next   = run_open_reg;
        count_next      = count_reg;
        step_next       = step_reg;
        clr_idx_next    = clr_idx_reg;
        report_next     = report_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_page_next   = out_page_reg;
        out_addr_next   = out_addr_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        mem_cmd         = '0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_raddr       = '0;

        case (state_reg)
            ST_CLEAR:
            begin
                mem_cmd.wr_en = 1'b1;
                mem_waddr     = clr_idx_reg;
                mem_wdata     = (clr_idx_reg == '0) ? NULL_LINK
                                                    : LINK_W'(clr_idx_reg) - LINK_W'(1);
                clr_idx_next  = clr_idx_reg + IDX_W'(1);
                if (clr_idx_reg == LAST_IDX)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == pfa_pkg::OP_ALLOC)
                    begin
                        count_next = page_count;
                        if (page_count == '0)
                        begin
                            report_next = pfa_pkg::STATUS_ZERO;
                            state_next  = ST_REPORT;
                        end
                        else if (page_count > COUNT_W'(MAX_REQUEST) || head_null)
                        begin
                            report_next = pfa_pkg::STATUS_SHORT;
                            state_next  = ST_REPORT;
                        end
                        else
                        begin
                            mem_cmd.rd_en = 1'b1;
                            mem_raddr     = IDX_W'(head_reg);
                            step_next     = COUNT_W'(1);
                            state_next    = ST_WALK;
                        end
                    end
                    else
                    begin
                        if (in_range)
                        begin
                            if (run_open_reg)
                            begin
                                mem_cmd.wr_en = 1'b1;
                                mem_waddr     = run_latest_reg;
                                mem_wdata     = LINK_W'(in_page);
                            end
                            else
                            begin
                                run_first_next = in_page;
                                run_open_next  = 1'b1;
                            end
                            run_latest_next = in_page;
                        end
                        if (run_end && (run_open_reg || in_range))
                        begin
                            state_next = ST_SPLICE;
                        end
                    end
                end
            end
            ST_WALK:
            begin
                if (step_reg == count_reg)
                begin
                    mem_cmd.rd_en = 1'b1;
                    mem_raddr     = IDX_W'(head_reg);
                    cur_next      = head_reg;
                    step_next     = COUNT_W'(1);
                    state_next    = ST_POP;
                end
                else if (rdata_null)
                begin
                    report_next = pfa_pkg::STATUS_SHORT;
                    state_next  = ST_REPORT;
                end
                else
                begin
                    mem_cmd.rd_en = 1'b1;
                    mem_raddr     = IDX_W'(mem_rdata);
                    step_next     = step_reg + COUNT_W'(1);
                end
            end
            ST_POP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = PAGE_W'(cur_idx);
                    out_addr_next   = ADDR_W'(cur_idx) << PAGE_SHIFT;
                    out_status_next = pfa_pkg::STATUS_GRANTED;
                    out_last_next   = step_reg == count_reg;
                    cur_next        = mem_rdata;
                    step_next       = step_reg + COUNT_W'(1);
                    if (!rdata_null)
                    begin
                        mem_cmd.rd_en = 1'b1;
                        mem_raddr     = IDX_W'(mem_rdata);
                    end
                    if (step_reg == count_reg)
                    begin
                        head_next  = mem_rdata;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    mem_cmd.rd_en = 1'b1;
                    mem_raddr     = cur_idx;
                end
            end
            ST_REPORT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_page_next   = '0;
                    out_addr_next   = '0;
                    out_status_next = report_reg;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            ST_SPLICE:
            begin
                mem_cmd.wr_en = 1'b1;
                mem_waddr     = run_latest_reg;
                mem_wdata     = head_reg;
                head_next     = LINK_W'(run_first_reg);
                run_open_next = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            head_reg       <= LINK_W'(PAGE_TOTAL - 1);
            cur_reg        <= '0;
            run_first_reg  <= '0;
            run_latest_reg <= '0;
            run_open_reg   <= 1'b0;
            count_reg      <= '0;
            step_reg       <= '0;
            clr_idx_reg    <= '0;
            report_reg     <= pfa_pkg::STATUS_GRANTED;
            out_valid_reg  <= 1'b0;
            out_page_reg   <= '0;
            out_addr_reg   <= '0;
            out_status_reg <= pfa_pkg::STATUS_GRANTED;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            cur_reg        <= cur_next;
            run_first_reg  <= run_first_next;
            run_latest_reg <= run_latest_next;
            run_open_reg   <= run_open_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            clr_idx_reg    <= clr_idx_next;
            report_reg     <= report_next;
            out_valid_reg  <= out_valid_next;
            out_page_reg   <= out_page_next;
            out_addr_reg   <= out_addr_next;
            out_status_reg <= out_status_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign in_stall     = state_reg != ST_IDLE;
    assign out_valid    = out_valid_reg;
    assign granted_page = out_page_reg;
    assign page_address = out_addr_reg;
    assign status       = out_status_reg;
    assign last_of_run  = out_last_reg;

endmodule

/* hw/rtl/pfa_checker.sv */
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg and page_frame_free_list_allocator_top_defines.svh.
`include "page_frame_free_list_allocator_top_defines.svh"

module pfa_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_stall,
    input logic                           opcode,
    input logic                           out_valid,
    input logic                           out_stall,
    input logic [pfa_pkg::PAGE_W-1:0]     granted_page,
    input logic [pfa_pkg::ADDR_W-1:0]     page_address,
    input logic [pfa_pkg::STATUS_W-1:0]   status,
    input logic                           last_of_run
);

    // A stalled result keeps its contents until the transfer completes.
    `PFA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(granted_page) && $stable(page_address) && $stable(status) && $stable(last_of_run), "result changed while stalled")

    // A failure or an empty request is always the only and final result.
    `PFA_ASSERT_NOW(a_fail_last, out_valid && status != pfa_pkg::STATUS_GRANTED, last_of_run, "failure result not marked last")

    // A failure carries no page.
    `PFA_ASSERT_NOW(a_fail_zero, out_valid && status != pfa_pkg::STATUS_GRANTED, granted_page == '0 && page_address == '0, "failure result carries a page")

    // A free transfer with an empty output side leaves it empty.
    `PFA_ASSERT_NEXT(a_free_silent, in_valid && !in_stall && opcode == pfa_pkg::OP_FREE && !out_valid, !out_valid, "free produced a result")

endmodule

bind page_frame_free_list_allocator_top pfa_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .opcode       (opcode),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .granted_page (granted_page),
    .page_address (page_address),
    .status       (status),
    .last_of_run  (last_of_run)
);

/* test/page_frame_free_list_allocator_top_tb.sv */
`timescale 1ns / 1ps
// Testbench for page_frame_free_list_allocator_top: a directed table, then random
// allocations and freed runs, results checked against a free-list predictor or typed rows.
// Depends on pfa_pkg and the allocator RTL.
module page_frame_free_list_allocator_top_tb;

    localparam int NULL_LINK     = pfa_pkg::PAGE_TOTAL_DEF;
    localparam int DIRECTED_ROWS = 25;
    localparam int RANDOM_ITEMS  = 405;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int TAIL_CYCLES   = 2 * pfa_pkg::MAX_REQUEST_DEF + 16;

    typedef logic [pfa_pkg::COUNT_W-1:0] count_t;
    typedef logic [pfa_pkg::PAGE_W-1:0]  page_t;
    typedef logic [pfa_pkg::ADDR_W-1:0]  addr_t;

    typedef struct packed {
        logic [pfa_pkg::PAGE_W-1:0]   page;
        logic [pfa_pkg::ADDR_W-1:0]   addr;
        logic [pfa_pkg::STATUS_W-1:0] status;
        logic                         last;
    } grant_t;

    typedef struct packed {
        logic                         op;
        logic [pfa_pkg::COUNT_W-1:0]  count;
        logic [pfa_pkg::PAGE_W-1:0]   page;
        logic                         run_last;
        logic                         typed;
        logic [pfa_pkg::PAGE_W-1:0]   want_page;
        logic [pfa_pkg::ADDR_W-1:0]   want_addr;
        logic [pfa_pkg::STATUS_W-1:0] want_status;
    } request_row_t;

    typedef enum int {STALL_NONE, STALL_LIGHT, STALL_PERIODIC, STALL_HEAVY} stall_mode_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic                         opcode = pfa_pkg::OP_ALLOC;
    logic [pfa_pkg::COUNT_W-1:0]  page_count = '0;
    logic [pfa_pkg::PAGE_W-1:0]   freed_page = '0;
    logic                         run_end = 1'b0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [pfa_pkg::PAGE_W-1:0]   granted_page;
    logic [pfa_pkg::ADDR_W-1:0]   page_address;
    logic [pfa_pkg::STATUS_W-1:0] status;
    logic                         last_of_run;

    logic [7:0]                   link_of [0:pfa_pkg::PAGE_TOTAL_DEF-1];
    logic [7:0]                   free_top;
    logic [7:0]                   free_tally;
    logic [pfa_pkg::PAGE_W-1:0]   run_head;
    logic [pfa_pkg::PAGE_W-1:0]   run_tail;
    logic                         run_building;

    grant_t                       grants_due [$];
    grant_t                       want_grant;
    logic [pfa_pkg::PAGE_W-1:0]   pages_out [$];
    int                           mismatch_count = 0;
    int                           cycle_count = 0;
    int                           burst_left = 0;
    bit                           smooth = 1'b0;
    stall_mode_t                  stall_mode = STALL_NONE;

    request_row_t directed [0:DIRECTED_ROWS-1] = '{
        '{pfa_pkg::OP_ALLOC, 7'd0,   7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_ZERO},
        '{pfa_pkg::OP_ALLOC, 7'd1,   7'd0,   1'b0, 1'b1, 7'd127, 28'hFE00000,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd65,  7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_SHORT},
        '{pfa_pkg::OP_ALLOC, 7'd127, 7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_SHORT},
        '{pfa_pkg::OP_ALLOC, 7'd64,  7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd64,  7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_SHORT},
        '{pfa_pkg::OP_ALLOC, 7'd63,  7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd1,   7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_SHORT},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd127, 7'd127, 1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd64,  1'b1, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd4,   7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_SHORT},
        '{pfa_pkg::OP_ALLOC, 7'd3,   7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd42,  1'b1, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd10,  1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd1,   7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd1,   7'd0,   1'b0, 1'b1, 7'd0,   28'h0,
          pfa_pkg::STATUS_SHORT},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd11,  1'b1, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd2,   7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd127, 1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd0,   1'b1, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd2,   7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd7,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_FREE,  7'd0,   7'd7,   1'b1, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED},
        '{pfa_pkg::OP_ALLOC, 7'd1,   7'd0,   1'b0, 1'b0, 7'd0,   28'h0,
          pfa_pkg::STATUS_GRANTED}
    };

    page_frame_free_list_allocator_top i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .opcode       (opcode),
        .page_count   (page_count),
        .freed_page   (freed_page),
        .run_end      (run_end),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .granted_page (granted_page),
        .page_address (page_address),
        .status       (status),
        .last_of_run  (last_of_run)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void queue_grant(input logic [pfa_pkg::PAGE_W-1:0] pg,
                                        input logic [pfa_pkg::STATUS_W-1:0] st,
                                        input logic last);
        grant_t g;
        g.page   = pg;
        g.addr   = addr_t'(pg) << pfa_pkg::PAGE_SHIFT_DEF;
        g.status = st;
        g.last   = last;
        grants_due.push_back(g);
    endfunction

    function automatic void predict_grants(input logic op,
                                           input logic [pfa_pkg::COUNT_W-1:0] count,
                                           input logic [pfa_pkg::PAGE_W-1:0] pg,
                                           input logic run_last,
                                           input bit keep);
        logic [7:0] walk;
        bit         short_list;
        int         k;
        if (op == pfa_pkg::OP_ALLOC)
        begin
            if (count == 0)
            begin
                if (keep)
                    queue_grant('0, pfa_pkg::STATUS_ZERO, 1'b1);
            end
            else if (count > pfa_pkg::MAX_REQUEST_DEF)
            begin
                if (keep)
                    queue_grant('0, pfa_pkg::STATUS_SHORT, 1'b1);
            end
            else
            begin
                // All or nothing: walk the links first, then pop.
                walk = free_top;
                short_list = 1'b0;
                for (k = 0; k < count; k++)
                begin
                    if (walk >= NULL_LINK)
                        short_list = 1'b1;
                    else
                        walk = link_of[walk[pfa_pkg::PAGE_W-1:0]];
                end
                if (short_list)
                begin
                    if (keep)
                        queue_grant('0, pfa_pkg::STATUS_SHORT, 1'b1);
                end
                else
                begin
                    for (k = 0; k < count; k++)
                    begin
                        if (keep)
                            queue_grant(free_top[pfa_pkg::PAGE_W-1:0],
                                        pfa_pkg::STATUS_GRANTED, k == count - 1);
                        pages_out.push_back(free_top[pfa_pkg::PAGE_W-1:0]);
                        free_top = link_of[free_top[pfa_pkg::PAGE_W-1:0]];
                        if (free_tally != 0)
                            free_tally--;
                    end
                end
            end
        end
        else
        begin
            if (!run_building)
            begin
                run_head = pg;
                run_building = 1'b1;
            end
            else
                link_of[run_tail] = {1'b0, pg};
            run_tail = pg;
            if (free_tally != 8'd255)
                free_tally++;
            if (run_last)
            begin
                link_of[run_tail] = free_top;
                free_top = {1'b0, run_head};
                run_building = 1'b0;
            end
        end
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("cycle %0d: %s got 0x%0h, expected 0x%0h", cycle_count, what, got, want);
    endtask

    task automatic send_item(input logic op, input logic [pfa_pkg::COUNT_W-1:0] count,
                             input logic [pfa_pkg::PAGE_W-1:0] pg, input logic run_last,
                             input bit drain, input bit keep);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            if (!smooth)
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 6);
        end
        burst_left--;
        if (drain && gap == 0)
            gap = 1;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            while (drain && grants_due.size() != 0)
                @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        page_count <= count;
        freed_page <= pg;
        run_end    <= run_last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_grants(op, count, pg, run_last, keep);
    endtask

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("page_frame_free_list_allocator_top_tb failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (grants_due.size() == 0)
                    report_mismatch("unexpected transfer, granted_page", 32'(granted_page), 0);
                else
                begin
                    want_grant = grants_due.pop_front();
                    if (granted_page !== want_grant.page)
                        report_mismatch("granted_page", 32'(granted_page),
                                        32'(want_grant.page));
                    if (page_address !== want_grant.addr)
                        report_mismatch("page_address", 32'(page_address),
                                        32'(want_grant.addr));
                    if (status !== want_grant.status)
                        report_mismatch("status", 32'(status), 32'(want_grant.status));
                    if (last_of_run !== want_grant.last)
                        report_mismatch("last_of_run", 32'(last_of_run),
                                        32'(want_grant.last));
                end
            end
            if (cycle_count % 64 == 0)
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            case (stall_mode)
                STALL_NONE:     out_stall <= 1'b0;
                STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
                STALL_PERIODIC: out_stall <= ((cycle_count % 5) < 2);
                default:        out_stall <= ($urandom_range(0, 3) != 0);
            endcase
        end
    end

    initial
    begin
        int                          row;
        int                          n;
        int                          pick;
        int                          idx;
        int                          cap;
        int                          listed;
        int                          run_left;
        int                          run_pages;
        bit                          drain;
        logic                        last;
        logic [pfa_pkg::COUNT_W-1:0] count;
        logic [pfa_pkg::PAGE_W-1:0]  pg;
        grant_t                      typed_grant;

        for (row = 0; row < pfa_pkg::PAGE_TOTAL_DEF; row++)
            link_of[row] = (row == 0) ? 8'(NULL_LINK) : 8'(row - 1);
        free_top     = 8'(NULL_LINK - 1);
        free_tally   = 8'(pfa_pkg::PAGE_TOTAL_DEF);
        run_head     = '0;
        run_tail     = '0;
        run_building = 1'b0;
        run_left     = 0;
        run_pages    = 0;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (row = 0; row < DIRECTED_ROWS; row++)
        begin
            send_item(directed[row].op, directed[row].count, directed[row].page,
                      directed[row].run_last, 1'b0, !directed[row].typed);
            if (directed[row].typed)
            begin
                typed_grant.page   = directed[row].want_page;
                typed_grant.addr   = directed[row].want_addr;
                typed_grant.status = directed[row].want_status;
                typed_grant.last   = 1'b1;
                grants_due.push_back(typed_grant);
            end
        end

        // The directed table leaves the free list empty with every page handed out.
        pages_out.delete();
        for (row = 0; row < pfa_pkg::PAGE_TOTAL_DEF; row++)
            pages_out.push_back(page_t'(row));

        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick   = $urandom_range(0, 99);
            drain  = (n % 150 == 0);
            smooth = ((n / 50) % 4) == 2;
            if (run_left == 0 && pick < 40 && pages_out.size() > 0)
                run_left = $urandom_range(1, pages_out.size() < 8 ? pages_out.size() : 8);
            if (run_left > 0 && pick < 70 && pages_out.size() > 0)
            begin
                idx = $urandom_range(0, pages_out.size() - 1);
                pg = pages_out[idx];
                pages_out.delete(idx);
                run_left--;
                run_pages++;
                last = (run_left == 0);
                if (last)
                    run_pages = 0;
                send_item(pfa_pkg::OP_FREE, count_t'($urandom_range(0, 127)), pg, last,
                          drain, 1'b1);
            end
            else if (pick < 94)
            begin
                listed = pfa_pkg::PAGE_TOTAL_DEF - pages_out.size() - run_pages;
                if (listed < 0)
                    listed = 0;
                cap = (listed > pfa_pkg::MAX_REQUEST_DEF) ? pfa_pkg::MAX_REQUEST_DEF : listed;
                idx = $urandom_range(0, 9);
                if (cap == 0)
                    count = count_t'($urandom_range(1, 4));
                else if (idx == 0 && listed < pfa_pkg::MAX_REQUEST_DEF)
                    count = count_t'(listed + 1);
                else if (idx == 1)
                    count = count_t'($urandom_range(1, cap));
                else
                    count = count_t'($urandom_range(1, cap < 12 ? cap : 12));
                send_item(pfa_pkg::OP_ALLOC, count, page_t'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), drain, 1'b1);
            end
            else
            begin
                count = (pick < 97) ? '0
                                    : count_t'($urandom_range(pfa_pkg::MAX_REQUEST_DEF + 1, 127));
                send_item(pfa_pkg::OP_ALLOC, count, page_t'($urandom_range(0, 127)),
                          1'($urandom_range(0, 1)), drain, 1'b1);
            end
        end

        in_valid <= 1'b0;
        while (grants_due.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("page_frame_free_list_allocator_top_tb passed");
        else
            $display("page_frame_free_list_allocator_top_tb failed");
        $finish;
    end

endmodule
